FILE: src/tdts_pkg.sv
// shared types and constants for the table dfa token scanner
package tdts_pkg;

  localparam int MaxTokenChars = 8;
  localparam int TextW         = 64;
  localparam int CountW        = 4;
  localparam int KindW         = 5;
  localparam int FifoDepth     = 4;
  localparam int PtrW          = $clog2(FifoDepth);

  // token kinds
  localparam logic [KindW-1:0] KInt     = 5'd0;
  localparam logic [KindW-1:0] KDefine  = 5'd1;
  localparam logic [KindW-1:0] KIf      = 5'd2;
  localparam logic [KindW-1:0] KWhile   = 5'd3;
  localparam logic [KindW-1:0] KFunc    = 5'd4;
  localparam logic [KindW-1:0] KReturn  = 5'd5;
  localparam logic [KindW-1:0] KIdent   = 5'd6;
  localparam logic [KindW-1:0] KPlus    = 5'd7;
  localparam logic [KindW-1:0] KMinus   = 5'd8;
  localparam logic [KindW-1:0] KStar    = 5'd9;
  localparam logic [KindW-1:0] KSlash   = 5'd10;
  localparam logic [KindW-1:0] KLParen  = 5'd11;
  localparam logic [KindW-1:0] KRParen  = 5'd12;
  localparam logic [KindW-1:0] KLBrace  = 5'd13;
  localparam logic [KindW-1:0] KRBrace  = 5'd14;
  localparam logic [KindW-1:0] KLBrack  = 5'd15;
  localparam logic [KindW-1:0] KRBrack  = 5'd16;
  localparam logic [KindW-1:0] KAssign  = 5'd17;
  localparam logic [KindW-1:0] KGt      = 5'd18;
  localparam logic [KindW-1:0] KLt      = 5'd19;
  localparam logic [KindW-1:0] KGe      = 5'd20;
  localparam logic [KindW-1:0] KLe      = 5'd21;
  localparam logic [KindW-1:0] KNe      = 5'd22;
  localparam logic [KindW-1:0] KEq      = 5'd23;
  localparam logic [KindW-1:0] KSemi    = 5'd24;
  localparam logic [KindW-1:0] KUnknown = 5'd25;
  localparam logic [KindW-1:0] KBadChar = 5'd26;
  localparam logic [KindW-1:0] KEnd     = 5'd27;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [TextW-1:0]  text;
    logic [CountW-1:0] length;
    logic              too_long;
    logic              last;
  } result_t;

endpackage

FILE: src/table_dfa_token_scanner_unit.sv
// top level of the table dfa token scanner
// Token scanner that takes one character per transaction and returns finished tokens.
// A character enters an input register, then one pass through the class decode,
// the eight-state transition table and the keyword/operator compare updates the
// open token and pushes zero, one or two tokens into a four-entry result queue.
// A new character is taken every cycle while the queue has room for two tokens;
// a character that ends a token and also yields a bad-character token, and an end
// of input with a token still open, each give two tokens. Leading blanks give no
// token. A token keeps its first eight characters; longer ones are flagged too_long
// and never match a keyword or operator. The character that ends a token is scanned
// again as the start of the next one. last_of_run marks the final token caused by
// one character transaction. No clearing pass is needed after reset.
module table_dfa_token_scanner_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        char_code,
  input  logic                              end_of_input,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tdts_pkg::KindW-1:0]        token_kind,
  output logic [tdts_pkg::TextW-1:0]        token_text,
  output logic [tdts_pkg::CountW-1:0]       token_length,
  output logic                              too_long,
  output logic                              last_of_run
);

  // input register
  logic       q_valid;
  logic [7:0] q_char;
  logic       q_eoi;

  logic              room;
  logic              fire;
  logic [1:0]        res_count;
  tdts_pkg::result_t res_first, res_second, out_item;

  // the step runs whenever a character is held and the queue can take two tokens
  assign fire     = q_valid && room;
  assign in_ready = !q_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      q_valid <= 1'b1;
    end else if (fire) begin
      q_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_char <= char_code;
      q_eoi  <= end_of_input;
    end
  end

  tdts_step u_step (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .char_code    (q_char),
    .end_of_input (q_eoi),
    .res_count    (res_count),
    .res_first    (res_first),
    .res_second   (res_second)
  );

  tdts_fifo u_fifo (
    .clk         (clk),
    .rst         (rst),
    .push_count  (res_count),
    .push_first  (res_first),
    .push_second (res_second),
    .room        (room),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

  assign token_kind   = out_item.kind;
  assign token_text   = out_item.text;
  assign token_length = out_item.length;
  assign too_long     = out_item.too_long;
  assign last_of_run  = out_item.last;

  // an end of input transaction always produces at least the end marker
  a_eoi_emits: assert property (@(posedge clk) disable iff (rst)
    (fire && q_eoi) |-> (res_count != 2'd0))
    else $error("end of input produced no token");

endmodule

FILE: src/tdts_step.sv
// scan state, character classes, transition table and token kind decode
module tdts_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          char_code,
  input  logic                end_of_input,
  output logic [1:0]          res_count,
  output tdts_pkg::result_t   res_first,
  output tdts_pkg::result_t   res_second
);

  typedef enum logic [2:0] {
    ClsBlank, ClsDigit, ClsLetter, ClsAngle, ClsEquals, ClsSign, ClsBang, ClsOther
  } char_class_t;

  typedef enum logic [7:0] {
    SIdle   = 8'b0000_0001,
    SNumber = 8'b0000_0010,
    SWord   = 8'b0000_0100,
    SRel    = 8'b0000_1000,
    SRel2   = 8'b0001_0000,
    SBang   = 8'b0010_0000,
    SNoteq  = 8'b0100_0000,
    SPunct  = 8'b1000_0000
  } scan_state_t;

  typedef struct packed {
    logic        done;
    scan_state_t nxt;
  } step_t;

  localparam logic [tdts_pkg::TextW-1:0] KwDefine = 64'h0000_656E_6966_6564;
  localparam logic [tdts_pkg::TextW-1:0] KwIf     = 64'h0000_0000_0000_6669;
  localparam logic [tdts_pkg::TextW-1:0] KwWhile  = 64'h0000_0065_6C69_6877;
  localparam logic [tdts_pkg::TextW-1:0] KwFunc   = 64'h0000_0000_636E_7566;
  localparam logic [tdts_pkg::TextW-1:0] KwReturn = 64'h0000_6E72_7574_6572;

  function automatic step_t next_of(scan_state_t st, char_class_t cls);
    step_t r;
    r.done = 1'b1;
    r.nxt  = SIdle;
    case (st)
      SIdle: begin
        r.done = 1'b0;
        case (cls)
          ClsDigit:            r.nxt = SNumber;
          ClsLetter:           r.nxt = SWord;
          ClsAngle, ClsEquals: r.nxt = SRel;
          ClsSign:             r.nxt = SPunct;
          ClsBang:             r.nxt = SBang;
          default:             r.done = 1'b1;
        endcase
      end
      SNumber: begin
        if (cls == ClsDigit) begin
          r.done = 1'b0;
          r.nxt  = SNumber;
        end
      end
      SWord: begin
        if (cls == ClsDigit || cls == ClsLetter) begin
          r.done = 1'b0;
          r.nxt  = SWord;
        end
      end
      SRel: begin
        if (cls == ClsEquals) begin
          r.done = 1'b0;
          r.nxt  = SRel2;
        end
      end
      SRel2: begin
        if (cls == ClsEquals) begin
          r.done = 1'b0;
          r.nxt  = SRel;
        end
      end
      SBang: begin
        if (cls == ClsEquals) begin
          r.done = 1'b0;
          r.nxt  = SNoteq;
        end
      end
      default: r.done = 1'b1;
    endcase
    return r;
  endfunction

  scan_state_t                   scan_state, scan_state_next;
  logic [tdts_pkg::TextW-1:0]    text_store, text_store_next;
  logic [tdts_pkg::CountW-1:0]   text_count, text_count_next;
  logic                          overflow_mark, overflow_mark_next;

  char_class_t                   cls;
  step_t                         cur_step, start_step;
  logic [tdts_pkg::KindW-1:0]    kind;
  logic                          plain;
  logic                          start_open;
  tdts_pkg::result_t             flush_res, bad_res, end_res;
  logic [1:0]                    n;

  // character class
  always_comb begin
    cls = ClsOther;
    if (char_code >= 8'h30 && char_code <= 8'h39) begin
      cls = ClsDigit;
    end else if ((char_code >= 8'h61 && char_code <= 8'h7A) ||
                 (char_code >= 8'h41 && char_code <= 8'h5A)) begin
      cls = ClsLetter;
    end else if (char_code == 8'h3C || char_code == 8'h3E) begin
      cls = ClsAngle;
    end else if (char_code == 8'h3D) begin
      cls = ClsEquals;
    end else if (char_code == 8'h2B || char_code == 8'h2D || char_code == 8'h2A ||
                 char_code == 8'h2F || char_code == 8'h3B || char_code == 8'h28 ||
                 char_code == 8'h29 || char_code == 8'h7B || char_code == 8'h7D ||
                 char_code == 8'h5B || char_code == 8'h5D) begin
      cls = ClsSign;
    end else if (char_code == 8'h21) begin
      cls = ClsBang;
    end else if (char_code == 8'h20 || char_code == 8'h0A || char_code == 8'h09) begin
      cls = ClsBlank;
    end
  end

  assign cur_step   = next_of(scan_state, cls);
  assign start_step = next_of(SIdle, cls);
  assign start_open = (cls != ClsBlank) && (cls != ClsOther);

  // kind of the open token
  always_comb begin
    plain = !overflow_mark;
    kind  = tdts_pkg::KUnknown;
    if (scan_state == SNumber) begin
      kind = tdts_pkg::KInt;
    end else if (plain && text_store == KwDefine &&
                 text_count == tdts_pkg::CountW'(6)) begin
      kind = tdts_pkg::KDefine;
    end else if (plain && text_store == KwIf && text_count == tdts_pkg::CountW'(2)) begin
      kind = tdts_pkg::KIf;
    end else if (plain && text_store == KwWhile &&
                 text_count == tdts_pkg::CountW'(5)) begin
      kind = tdts_pkg::KWhile;
    end else if (plain && text_store == KwFunc && text_count == tdts_pkg::CountW'(4)) begin
      kind = tdts_pkg::KFunc;
    end else if (plain && text_store == KwReturn &&
                 text_count == tdts_pkg::CountW'(6)) begin
      kind = tdts_pkg::KReturn;
    end else if (scan_state == SWord) begin
      kind = tdts_pkg::KIdent;
    end else if (plain && text_count == tdts_pkg::CountW'(1)) begin
      case (text_store[7:0])
        8'h2B:   kind = tdts_pkg::KPlus;
        8'h2D:   kind = tdts_pkg::KMinus;
        8'h2A:   kind = tdts_pkg::KStar;
        8'h2F:   kind = tdts_pkg::KSlash;
        8'h28:   kind = tdts_pkg::KLParen;
        8'h29:   kind = tdts_pkg::KRParen;
        8'h7B:   kind = tdts_pkg::KLBrace;
        8'h7D:   kind = tdts_pkg::KRBrace;
        8'h5B:   kind = tdts_pkg::KLBrack;
        8'h5D:   kind = tdts_pkg::KRBrack;
        8'h3D:   kind = tdts_pkg::KAssign;
        8'h3E:   kind = tdts_pkg::KGt;
        8'h3C:   kind = tdts_pkg::KLt;
        8'h3B:   kind = tdts_pkg::KSemi;
        default: kind = tdts_pkg::KUnknown;
      endcase
    end else if (plain && text_count == tdts_pkg::CountW'(2)) begin
      case (text_store[15:0])
        16'h3D3E: kind = tdts_pkg::KGe;
        16'h3D3C: kind = tdts_pkg::KLe;
        16'h3D21: kind = tdts_pkg::KNe;
        16'h3D3D: kind = tdts_pkg::KEq;
        default:  kind = tdts_pkg::KUnknown;
      endcase
    end
  end

  always_comb begin
    flush_res.kind     = kind;
    flush_res.text     = text_store;
    flush_res.length   = text_count;
    flush_res.too_long = overflow_mark;
    flush_res.last     = 1'b0;

    bad_res.kind     = tdts_pkg::KBadChar;
    bad_res.text     = tdts_pkg::TextW'(char_code);
    bad_res.length   = tdts_pkg::CountW'(1);
    bad_res.too_long = 1'b0;
    bad_res.last     = 1'b0;

    end_res.kind     = tdts_pkg::KEnd;
    end_res.text     = '0;
    end_res.length   = '0;
    end_res.too_long = 1'b0;
    end_res.last     = 1'b0;
  end

  // one step of the scanner
  always_comb begin
    scan_state_next    = scan_state;
    text_store_next    = text_store;
    text_count_next    = text_count;
    overflow_mark_next = overflow_mark;
    res_first          = '0;
    res_second         = '0;
    n                  = 2'd0;

    if (end_of_input) begin
      if (scan_state != SIdle) begin
        res_first  = flush_res;
        res_second = end_res;
        n          = 2'd2;
      end else begin
        res_first = end_res;
        n         = 2'd1;
      end
      scan_state_next    = SIdle;
      text_store_next    = '0;
      text_count_next    = '0;
      overflow_mark_next = 1'b0;
    end else if (scan_state == SIdle || cur_step.done) begin
      if (scan_state != SIdle) begin
        // token ends here, ending char is rescanned from idle
        res_first          = flush_res;
        n                  = 2'd1;
        scan_state_next    = SIdle;
        text_store_next    = '0;
        text_count_next    = '0;
        overflow_mark_next = 1'b0;
      end
      if (cls == ClsOther) begin
        if (n == 2'd1) begin
          res_second = bad_res;
        end else begin
          res_first = bad_res;
        end
        n = n + 2'd1;
      end else if (start_open) begin
        scan_state_next    = start_step.nxt;
        text_store_next    = tdts_pkg::TextW'(char_code);
        text_count_next    = tdts_pkg::CountW'(1);
        overflow_mark_next = 1'b0;
      end
    end else begin
      if (text_count < tdts_pkg::CountW'(tdts_pkg::MaxTokenChars)) begin
        for (int i = 0; i < tdts_pkg::MaxTokenChars; i++) begin
          if (text_count == tdts_pkg::CountW'(i)) begin
            text_store_next[8*i +: 8] = char_code;
          end
        end
        text_count_next = text_count + tdts_pkg::CountW'(1);
      end else begin
        overflow_mark_next = 1'b1;
      end
      scan_state_next = cur_step.nxt;
    end

    if (n == 2'd1) begin
      res_first.last = 1'b1;
    end else if (n == 2'd2) begin
      res_second.last = 1'b1;
    end
    res_count = fire ? n : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state    <= SIdle;
      text_store    <= '0;
      text_count    <= '0;
      overflow_mark <= 1'b0;
    end else if (fire) begin
      scan_state    <= scan_state_next;
      text_store    <= text_store_next;
      text_count    <= text_count_next;
      overflow_mark <= overflow_mark_next;
    end
  end

  a_eoi_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && end_of_input) |=> (scan_state == SIdle && text_count == '0))
    else $error("end of input did not return the scanner to idle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (text_count <= tdts_pkg::CountW'(tdts_pkg::MaxTokenChars)) &&
    ((scan_state == SIdle) == (text_count == '0)))
    else $error("held character count out of step with scan state");

endmodule

FILE: src/tdts_fifo.sv
// result queue taking up to two tokens per cycle and giving one
module tdts_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_count,
  input  tdts_pkg::result_t push_first,
  input  tdts_pkg::result_t push_second,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output tdts_pkg::result_t out_item
);

  tdts_pkg::result_t           entries [tdts_pkg::FifoDepth];
  logic [tdts_pkg::PtrW-1:0]   wr_ptr, rd_ptr;
  logic [tdts_pkg::PtrW:0]     count, count_next;
  logic                        pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_item  = entries[rd_ptr];
  assign room      = (count <= (tdts_pkg::PtrW + 1)'(tdts_pkg::FifoDepth - 2));

  always_comb begin
    count_next = count + (tdts_pkg::PtrW + 1)'(push_count);
    if (pop) begin
      count_next = count_next - (tdts_pkg::PtrW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push_first;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr + tdts_pkg::PtrW'(1)] <= push_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + tdts_pkg::PtrW'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + tdts_pkg::PtrW'(1);
      end
      count <= count_next;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    (push_count != 2'd0) |-> room)
    else $error("tokens pushed without room in the result queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (tdts_pkg::PtrW + 1)'(tdts_pkg::FifoDepth))
    else $error("result queue count beyond depth");

endmodule

FILE: tb/sv/table_dfa_token_scanner_unit_tb.sv
// testbench for the token scanner: directed and random text checked against a built-in token predictor
`timescale 1ns / 1ps

module table_dfa_token_scanner_unit_tb;

  typedef enum logic [2:0] {
    ClsBlank, ClsDigit, ClsLetter, ClsAngle, ClsEq, ClsSign, ClsBang, ClsOther
  } char_class_t;

  typedef enum logic [2:0] {
    StIdle, StNumber, StWord, StRel, StRel2, StBang, StNotEq, StPunct
  } scan_state_t;

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_ready;
  logic [7:0]                  char_code;
  logic                        end_of_input;
  logic                        out_valid;
  logic                        out_ready;
  logic [tdts_pkg::KindW-1:0]  token_kind;
  logic [tdts_pkg::TextW-1:0]  token_text;
  logic [tdts_pkg::CountW-1:0] token_length;
  logic                        too_long;
  logic                        last_of_run;

  table_dfa_token_scanner_unit DUT (.*);

  function automatic char_class_t classify_char(input logic [7:0] c);
    if (c >= "0" && c <= "9") return ClsDigit;
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) return ClsLetter;
    if (c == "<" || c == ">") return ClsAngle;
    if (c == "=") return ClsEq;
    if (c == "+" || c == "-" || c == "*" || c == "/" || c == ";" || c == "(" ||
        c == ")" || c == "{" || c == "}" || c == "[" || c == "]") return ClsSign;
    if (c == "!") return ClsBang;
    if (c == " " || c == "\n" || c == "\t") return ClsBlank;
    return ClsOther;
  endfunction

  // tracks the open token and holds the tokens still owed by the block
  class token_ledger;
    tdts_pkg::result_t           pending_tokens[$];
    int                          errors;
    scan_state_t                 st;
    logic [tdts_pkg::TextW-1:0]  txt;
    logic [tdts_pkg::CountW-1:0] cnt;
    logic                        ovf;

    string                      keyword_text[5] = '{"define", "if", "while", "func",
                                                    "return"};
    logic [tdts_pkg::KindW-1:0] keyword_kind[5] = '{tdts_pkg::KDefine, tdts_pkg::KIf,
                                                    tdts_pkg::KWhile, tdts_pkg::KFunc,
                                                    tdts_pkg::KReturn};
    string                      op_text[18] = '{"+", "-", "*", "/", "(", ")", "{", "}",
                                                "[", "]", "=", ">", "<", ">=", "<=",
                                                "!=", "==", ";"};
    logic [tdts_pkg::KindW-1:0] op_kind[18] = '{tdts_pkg::KPlus, tdts_pkg::KMinus,
                                                tdts_pkg::KStar, tdts_pkg::KSlash,
                                                tdts_pkg::KLParen, tdts_pkg::KRParen,
                                                tdts_pkg::KLBrace, tdts_pkg::KRBrace,
                                                tdts_pkg::KLBrack, tdts_pkg::KRBrack,
                                                tdts_pkg::KAssign, tdts_pkg::KGt,
                                                tdts_pkg::KLt, tdts_pkg::KGe,
                                                tdts_pkg::KLe, tdts_pkg::KNe,
                                                tdts_pkg::KEq, tdts_pkg::KSemi};

    function new();
      errors = 0;
      clear_token();
    endfunction

    function void clear_token();
      st  = StIdle;
      txt = '0;
      cnt = '0;
      ovf = 1'b0;
    endfunction

    function void push_token(input logic [tdts_pkg::KindW-1:0] kind,
                             input logic [tdts_pkg::TextW-1:0] text,
                             input logic [tdts_pkg::CountW-1:0] len, input logic tl);
      tdts_pkg::result_t r;
      r.kind     = kind;
      r.text     = text;
      r.length   = len;
      r.too_long = tl;
      r.last     = 1'b0;
      pending_tokens.push_back(r);
    endfunction

    // an overflowed token never equals a fixed spelling
    function bit text_is(input string w);
      logic [tdts_pkg::TextW-1:0] packed_w;
      packed_w = '0;
      if (ovf || cnt != w.len()) return 1'b0;
      for (int i = 0; i < w.len(); i++) packed_w[8*i +: 8] = w[i];
      return packed_w == txt;
    endfunction

    function logic [tdts_pkg::KindW-1:0] kind_of();
      if (st == StNumber) return tdts_pkg::KInt;
      foreach (keyword_text[i]) if (text_is(keyword_text[i])) return keyword_kind[i];
      if (st == StWord) return tdts_pkg::KIdent;
      foreach (op_text[i]) if (text_is(op_text[i])) return op_kind[i];
      return tdts_pkg::KUnknown;
    endfunction

    function void close_token();
      push_token(kind_of(), txt, cnt, ovf);
      clear_token();
    endfunction

    // first character of a token; blanks are skipped, stray bytes come out at once
    function void open_token(input logic [7:0] c);
      char_class_t k;
      k = classify_char(c);
      case (k)
        ClsBlank: ;
        ClsOther: push_token(tdts_pkg::KBadChar, {56'b0, c}, 4'd1, 1'b0);
        default: begin
          case (k)
            ClsDigit:        st = StNumber;
            ClsLetter:       st = StWord;
            ClsAngle, ClsEq: st = StRel;
            ClsSign:         st = StPunct;
            default:         st = StBang;
          endcase
          txt = {56'b0, c};
          cnt = 4'd1;
          ovf = 1'b0;
        end
      endcase
    endfunction

    // returns 1 while the open token goes on
    function bit table_step(input scan_state_t s, input char_class_t k,
                            output scan_state_t ns);
      ns = s;
      case (s)
        StNumber: return k == ClsDigit;
        StWord:   return k == ClsDigit || k == ClsLetter;
        StRel: begin
          ns = StRel2;
          return k == ClsEq;
        end
        StRel2: begin
          ns = StRel;
          return k == ClsEq;
        end
        StBang: begin
          ns = StNotEq;
          return k == ClsEq;
        end
        default: return 1'b0;
      endcase
    endfunction

    function void note_char(input logic [7:0] c, input logic eoi);
      int          first;
      scan_state_t ns;
      first = pending_tokens.size();
      if (eoi) begin
        if (st != StIdle) close_token();
        push_token(tdts_pkg::KEnd, '0, '0, 1'b0);
      end else if (st == StIdle) begin
        open_token(c);
      end else if (!table_step(st, classify_char(c), ns)) begin
        // ending character is scanned again as a fresh start
        close_token();
        open_token(c);
      end else begin
        if (cnt < tdts_pkg::MaxTokenChars) begin
          txt[8*cnt +: 8] = c;
          cnt++;
        end else begin
          ovf = 1'b1;
        end
        st = ns;
      end
      if (pending_tokens.size() > first) pending_tokens[$].last = 1'b1;
    endfunction

    function int pending();
      return pending_tokens.size();
    endfunction

    function void field_ok(input string name, input logic [63:0] e, input logic [63:0] a);
      if (e !== a) begin
        $display("%0t mismatch %s: expected %h actual %h", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_token(input tdts_pkg::result_t got);
      tdts_pkg::result_t exp;
      if (pending_tokens.size() == 0) begin
        $display("%0t unexpected token: expected none actual kind %0d text %h",
                 $time, got.kind, got.text);
        errors++;
        return;
      end
      exp = pending_tokens.pop_front();
      field_ok("token_kind", exp.kind, got.kind);
      field_ok("token_text", exp.text, got.text);
      field_ok("token_length", exp.length, got.length);
      field_ok("too_long", exp.too_long, got.too_long);
      field_ok("last_of_run", exp.last, got.last);
    endfunction
  endclass

  token_ledger ledger = new();

  int char_count;
  bit no_idle;
  bit long_hold_req;

  string keyword_list[5] = '{"define", "if", "while", "func", "return"};
  string op_list[25] = '{"+", "-", "*", "/", "(", ")", "{", "}", "[", "]", "=", ">", "<",
                         ">=", "<=", "!=", "==", ";", "!", "===", "<==", "=>", "<<", "!!",
                         "!=="};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // one transaction on the character side, after a random gap
  task automatic send_char(input logic [7:0] c, input logic eoi);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    char_code    <= c;
    end_of_input <= eoi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ledger.note_char(c, eoi);
  endtask

  task automatic feed_char(input logic [7:0] c, input logic eoi);
    send_char(c, eoi);
    char_count++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) feed_char(s[i], 1'b0);
  endtask

  function automatic logic [7:0] random_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] random_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] random_blank();
    int r;
    r = $urandom_range(0, 2);
    return (r == 0) ? " " : (r == 1) ? "\n" : "\t";
  endfunction

  // stimulus
  initial begin
    int  pick;
    int  len;
    bit  hold_done;
    bit  pause_done;
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    char_code     <= '0;
    end_of_input  <= 1'b0;
    char_count    = 0;
    no_idle       = 1'b0;
    long_hold_req = 1'b0;
    hold_done     = 1'b0;
    pause_done    = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: byte extremes, relational and bang forms, bad char after an open token,
    // flush at end of input, bare end marker, long token
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_text(" if(<=!=!#9a");
    send_char(8'($urandom_range(0, 255)), 1'b1);
    send_char(8'hFF, 1'b1);
    send_text("returnxyz\t");

    char_count = 0;
    while (char_count < 950) begin
      if (!hold_done && char_count >= 300) begin
        hold_done     = 1'b1;
        long_hold_req = 1'b1;
      end
      if (!pause_done && char_count >= 620) begin
        // drain everything before going on
        pause_done = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (ledger.pending() != 0) @(posedge clk);
      end
      no_idle = (char_count >= 420 && char_count < 520);

      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_text(keyword_list[$urandom_range(0, 4)]);
        if ($urandom_range(0, 2) == 0) begin
          len = $urandom_range(1, 4);
          repeat (len) feed_char($urandom_range(0, 3) == 0 ? random_digit() : random_letter(),
                                 1'b0);
        end
      end else if (pick < 35) begin
        len = $urandom_range(1, 12);
        feed_char(random_letter(), 1'b0);
        repeat (len - 1)
          feed_char($urandom_range(0, 3) == 0 ? random_digit() : random_letter(), 1'b0);
      end else if (pick < 50) begin
        len = $urandom_range(1, 11);
        repeat (len) feed_char(random_digit(), 1'b0);
      end else if (pick < 72) begin
        send_text(op_list[$urandom_range(0, 24)]);
      end else if (pick < 82) begin
        len = $urandom_range(1, 3);
        repeat (len) feed_char(random_blank(), 1'b0);
      end else if (pick < 96) begin
        feed_char(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        feed_char(8'($urandom_range(0, 255)), 1'b1);
      end
      if ($urandom_range(0, 1) == 0) feed_char(random_blank(), 1'b0);
    end
    no_idle = 1'b0;

    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // token side: random stalls plus one long hold-off that backs up the block
  initial begin
    int                stall;
    tdts_pkg::result_t got;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (80) @(posedge clk);
        long_hold_req = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.kind     = token_kind;
      got.text     = token_text;
      got.length   = token_length;
      got.too_long = too_long;
      got.last     = last_of_run;
      ledger.check_token(got);
    end
  end

endmodule

FILE: filelist.f
src/tdts_pkg.sv
src/tdts_step.sv
src/tdts_fifo.sv
src/table_dfa_token_scanner_unit.sv
tb/sv/table_dfa_token_scanner_unit_tb.sv
